// ===== sv/wmf_pkg.sv =====
// Shared types and constants of the windowed median filter.
`timescale 1ns / 1ps

package wmf_pkg;

  // Fixed field widths
  localparam int unsigned PIX_W     = 16;
  localparam int unsigned CFG_DW    = 11;
  localparam int unsigned CFG_AW    = 2;
  localparam int unsigned RAD_CFG_W = 2;

  // Input item kinds
  typedef enum logic [0:0] {
    REQ_PIXEL = 1'b0,
    REQ_FLUSH = 1'b1
  } req_e;

  // Configuration register indexes
  typedef enum logic [CFG_AW-1:0] {
    CFG_RADIUS = 2'd0,
    CFG_WIDTH  = 2'd1,
    CFG_HEIGHT = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    req_e              req_type;
    logic [PIX_W-1:0]  pixel;
  } in_item_t;

  typedef struct packed {
    logic [PIX_W-1:0]  median_value;
    logic              frame_end;
  } out_item_t;

endpackage

// ===== sv/wmf_ram.sv =====
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps

module wmf_ram #(
  parameter int unsigned DW    = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [DW-1:0]            wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [DW-1:0]            rdata_o
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, data holds while not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/windowed_median_filter_top.sv =====
// Streaming 2D median filter over a clipped square window, top level.
// Each result passes through the registered median pipeline stages into the output register.
// Throughput: one item per cycle; the input stalls only while the output register is
// full and stalled, and after a frame of fewer than radius*(width+1) pixels, while
// internal column pushes make up the rest of the output lag.
// Reset (async, active low) clears all valid bits and position counters and loads
// radius 1, width 1024, height 1024; line store contents stay undefined.
`timescale 1ns / 1ps

module windowed_median_filter_top #(
  parameter int unsigned MAX_RADIUS = 2,
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  wmf_pkg::in_item_t                 in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output wmf_pkg::out_item_t                out_data_o,
  input  logic                              cfg_we_i,
  input  logic [wmf_pkg::CFG_AW-1:0]        cfg_idx_i,
  input  logic [wmf_pkg::CFG_DW-1:0]        cfg_data_i
);

  localparam int unsigned PW   = wmf_pkg::PIX_W;
  localparam int unsigned SIDE = 2 * MAX_RADIUS + 1;
  localparam int unsigned NWIN = SIDE * SIDE;
  localparam int unsigned NLB  = 2 * MAX_RADIUS;
  localparam int unsigned LBW  = NLB * PW;
  localparam int unsigned CW   = $clog2(MAX_WIDTH);
  localparam int unsigned WW   = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HW   = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned ORW  = $clog2(MAX_HEIGHT);
  localparam int unsigned PRW  = $clog2(MAX_HEIGHT + MAX_RADIUS + 1);
  localparam int unsigned RW   = $clog2(MAX_RADIUS + 1);
  localparam int unsigned LGW  = $clog2(MAX_RADIUS * MAX_WIDTH + MAX_RADIUS + 1);
  localparam int unsigned RKW  = $clog2(NWIN);
  localparam int unsigned NW   = $clog2(NWIN + 1);

  // Configuration registers
  logic [wmf_pkg::RAD_CFG_W-1:0] rad_cfg_q;
  logic [wmf_pkg::CFG_DW-1:0]    wid_cfg_q;
  logic [wmf_pkg::CFG_DW-1:0]    hgt_cfg_q;

  // Position counters
  logic [CW-1:0]  push_col_q;
  logic [PRW-1:0] push_row_q;
  logic [CW-1:0]  out_col_q;
  logic [ORW-1:0] out_row_q;
  logic [LGW-1:0] lead_q;

  // Effective settings
  logic [RW-1:0]  rad;
  logic [WW-1:0]  wid;
  logic [HW-1:0]  hgt;
  logic [LGW-1:0] lag;

  // Front control
  logic adv, complete, inject, take, is_flush, push, emit, last, cfg_hit;

  // Stage 1
  logic           s1_v_q, s1_emit_q, s1_last_q, s1_byp_q;
  logic [PW-1:0]  s1_pix_q;
  logic [ORW-1:0] s1_row_q;
  logic [CW-1:0]  s1_col_q;
  logic [CW-1:0]  s1_pc_q;
  logic [LBW-1:0] ram_rd, lb_rd, lb_wr, byp_q;
  logic [SIDE*PW-1:0] col;
  logic [SIDE*PW-1:0] win_q [SIDE];
  logic [SIDE*PW-1:0] win_d [SIDE];
  logic [SIDE-1:0]    row_ok, col_ok;
  logic [NWIN-1:0]    mask_d;
  logic [PW-1:0]      val_d [NWIN];

  // Stages 2..5 and output
  logic               s2_v_q, s2_last_q;
  logic [PW-1:0]      s2_val_q [NWIN];
  logic [NWIN-1:0]    s2_mask_q;
  logic [NWIN-1:0]    lt_d [NWIN];
  logic               s3_v_q, s3_last_q;
  logic [PW-1:0]      s3_val_q [NWIN];
  logic [NWIN-1:0]    s3_mask_q;
  logic [NWIN-1:0]    s3_lt_q [NWIN];
  logic               s4_v_q, s4_last_q;
  logic [PW-1:0]      s4_val_q [NWIN];
  logic [NWIN-1:0]    s4_mask_q;
  logic [RKW-1:0]     s4_rank_q [NWIN];
  logic [NW-1:0]      s4_n_q;
  logic [RKW-1:0]     lo, hi;
  logic [PW-1:0]      a_d, b_d;
  logic               s5_v_q, s5_last_q;
  logic [PW-1:0]      s5_a_q, s5_b_q;
  logic               out_valid_q;
  wmf_pkg::out_item_t out_data_q;

  // Clamp settings and derive the output lag
  always_comb begin
    if (rad_cfg_q == '0) begin
      rad = RW'(1);
    end else if (32'(rad_cfg_q) > MAX_RADIUS) begin
      rad = RW'(MAX_RADIUS);
    end else begin
      rad = RW'(rad_cfg_q);
    end
    if (wid_cfg_q == '0) begin
      wid = WW'(1);
    end else if (32'(wid_cfg_q) > MAX_WIDTH) begin
      wid = WW'(MAX_WIDTH);
    end else begin
      wid = WW'(wid_cfg_q);
    end
    if (hgt_cfg_q == '0) begin
      hgt = HW'(1);
    end else if (32'(hgt_cfg_q) > MAX_HEIGHT) begin
      hgt = HW'(MAX_HEIGHT);
    end else begin
      hgt = HW'(hgt_cfg_q);
    end
    lag = LGW'(32'(rad) * 32'(wid) + 32'(rad));
  end

  // Front decisions: every push moves one raster column into the window
  always_comb begin
    adv        = !out_valid_q || !out_stall_i;
    complete   = 32'(push_row_q) >= 32'(hgt);
    inject     = complete && (lead_q < lag);
    in_stall_o = !adv || inject;
    take       = in_valid_i && !in_stall_o;
    is_flush   = in_data_i.req_type == wmf_pkg::REQ_FLUSH;
    push       = (adv && inject) || (take && (is_flush == complete));
    emit       = push && (lead_q == lag);
    last       = emit && (32'(out_row_q) == 32'(hgt) - 1)
                      && (32'(out_col_q) == 32'(wid) - 1);
    cfg_hit    = (cfg_idx_i == wmf_pkg::CFG_RADIUS) || (cfg_idx_i == wmf_pkg::CFG_WIDTH)
              || (cfg_idx_i == wmf_pkg::CFG_HEIGHT);
  end

  // Configuration and position counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rad_cfg_q  <= wmf_pkg::RAD_CFG_W'(1);
      wid_cfg_q  <= wmf_pkg::CFG_DW'(1024);
      hgt_cfg_q  <= wmf_pkg::CFG_DW'(1024);
      push_col_q <= '0;
      push_row_q <= '0;
      out_col_q  <= '0;
      out_row_q  <= '0;
      lead_q     <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        wmf_pkg::CFG_RADIUS: rad_cfg_q <= cfg_data_i[wmf_pkg::RAD_CFG_W-1:0];
        wmf_pkg::CFG_WIDTH:  wid_cfg_q <= cfg_data_i;
        wmf_pkg::CFG_HEIGHT: hgt_cfg_q <= cfg_data_i;
        default: ;
      endcase
      if (cfg_hit) begin
        push_col_q <= '0;
        push_row_q <= '0;
        out_col_q  <= '0;
        out_row_q  <= '0;
        lead_q     <= '0;
      end
    end else if (push) begin
      if (last) begin
        push_col_q <= '0;
        push_row_q <= '0;
        out_col_q  <= '0;
        out_row_q  <= '0;
        lead_q     <= '0;
      end else begin
        if (32'(push_col_q) == 32'(wid) - 1) begin
          push_col_q <= '0;
          push_row_q <= push_row_q + PRW'(1);
        end else begin
          push_col_q <= push_col_q + CW'(1);
        end
        if (emit) begin
          if (32'(out_col_q) == 32'(wid) - 1) begin
            out_col_q <= '0;
            out_row_q <= out_row_q + ORW'(1);
          end else begin
            out_col_q <= out_col_q + CW'(1);
          end
        end else begin
          lead_q <= lead_q + LGW'(1);
        end
      end
    end
  end

  // Stage 1 control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q    <= 1'b0;
      s1_emit_q <= 1'b0;
      s1_last_q <= 1'b0;
    end else if (adv) begin
      s1_v_q    <= push;
      s1_emit_q <= emit;
      s1_last_q <= last;
    end
  end

  // Stage 1 payload; bypass covers a read of the column being written
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_pix_q <= in_data_i.pixel;
      s1_row_q <= out_row_q;
      s1_col_q <= out_col_q;
      s1_pc_q  <= push_col_q;
      s1_byp_q <= s1_v_q && (push_col_q == s1_pc_q);
      if (s1_v_q) begin
        byp_q <= lb_wr;
      end
    end
  end

  // Line store: one word per column holds the previous rows
  wmf_ram #(
    .DW    (LBW),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (adv && s1_v_q),
    .waddr_i (s1_pc_q),
    .wdata_i (lb_wr),
    .re_i    (push),
    .raddr_i (push_col_q),
    .rdata_o (ram_rd)
  );

  // New column and window shift
  always_comb begin
    lb_rd = s1_byp_q ? byp_q : ram_rd;
    lb_wr = {lb_rd[LBW-PW-1:0], s1_pix_q};
    col   = {lb_rd, s1_pix_q};
    win_d[0] = col;
    for (int unsigned d = 1; d < SIDE; d++) begin
      win_d[d] = win_q[d-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s1_v_q) begin
      for (int unsigned d = 0; d < SIDE; d++) begin
        win_q[d] <= win_d[d];
      end
    end
  end

  // Window clipping: entry (d, i) is column c+rad-d, row r+rad-i
  always_comb begin
    int unsigned rsum, csum;
    rsum = 32'(s1_row_q) + 32'(rad);
    csum = 32'(s1_col_q) + 32'(rad);
    for (int unsigned i = 0; i < SIDE; i++) begin
      row_ok[i] = (i <= 2 * 32'(rad)) && (rsum >= i) && ((rsum - i) < 32'(hgt));
      col_ok[i] = (i <= 2 * 32'(rad)) && (csum >= i) && ((csum - i) < 32'(wid));
    end
    for (int unsigned d = 0; d < SIDE; d++) begin
      for (int unsigned i = 0; i < SIDE; i++) begin
        mask_d[d*SIDE+i] = col_ok[d] && row_ok[i];
        val_d[d*SIDE+i]  = win_d[d][i*PW +: PW];
      end
    end
  end

  // Pairwise order: f sorts before e, ties broken by position
  always_comb begin
    for (int unsigned e = 0; e < NWIN; e++) begin
      for (int unsigned f = 0; f < NWIN; f++) begin
        lt_d[e][f] = s2_mask_q[f] && ((s2_val_q[f] < s2_val_q[e]) ||
                     ((s2_val_q[f] == s2_val_q[e]) && (f < e)));
      end
    end
  end

  // Pick the two middle ranks
  always_comb begin
    lo  = RKW'((s4_n_q - NW'(1)) >> 1);
    hi  = RKW'(s4_n_q >> 1);
    a_d = '0;
    b_d = '0;
    for (int unsigned e = 0; e < NWIN; e++) begin
      if (s4_mask_q[e] && (s4_rank_q[e] == lo)) begin
        a_d = a_d | s4_val_q[e];
      end
      if (s4_mask_q[e] && (s4_rank_q[e] == hi)) begin
        b_d = b_d | s4_val_q[e];
      end
    end
  end

  // Valid bits of stages 2..5 and the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q      <= 1'b0;
      s3_v_q      <= 1'b0;
      s4_v_q      <= 1'b0;
      s5_v_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      s2_v_q      <= s1_v_q && s1_emit_q;
      s3_v_q      <= s2_v_q;
      s4_v_q      <= s3_v_q;
      s5_v_q      <= s4_v_q;
      out_valid_q <= s5_v_q;
    end
  end

  // Median pipeline payload
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_last_q <= s1_last_q;
      s2_mask_q <= mask_d;
      s3_last_q <= s2_last_q;
      s3_mask_q <= s2_mask_q;
      s4_last_q <= s3_last_q;
      s4_mask_q <= s3_mask_q;
      s4_n_q    <= NW'($countones(s3_mask_q));
      for (int unsigned e = 0; e < NWIN; e++) begin
        s2_val_q[e]  <= val_d[e];
        s3_val_q[e]  <= s2_val_q[e];
        s3_lt_q[e]   <= lt_d[e];
        s4_val_q[e]  <= s3_val_q[e];
        s4_rank_q[e] <= RKW'($countones(s3_lt_q[e]));
      end
      s5_last_q <= s4_last_q;
      s5_a_q    <= a_d;
      s5_b_q    <= b_d;
      out_data_q.median_value <= PW'(((PW+1)'(s5_a_q) + (PW+1)'(s5_b_q)) >> 1);
      out_data_q.frame_end    <= s5_last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== sv/wmf_checker.sv =====
// Port-level checks of the windowed median filter, bound to the top level.
`timescale 1ns / 1ps

module wmf_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_stall_i,
  input logic               out_valid_i,
  input logic               out_stall_i,
  input wmf_pkg::out_item_t out_data_i
);

  // A stalled item stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> out_valid_i)
    else $error("output item dropped while stalled");

  // A stalled item does not change
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> $stable(out_data_i))
    else $error("output item changed while stalled");

  // Reset empties the output register
  a_rst_empty: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_i)
    else $error("output valid during reset");

  // A full, stalled output freezes the pipe, so the input must stall too
  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |-> in_stall_i)
    else $error("input accepted while output blocked");

endmodule

bind windowed_median_filter_top wmf_checker u_wmf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_i  (in_stall_o),
  .out_valid_i (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_i  (out_data_o)
);

// ===== verif/testbench.sv =====
// Self-checking testbench for the windowed median filter top level.
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned MAX_R = 2;
  localparam int unsigned MAX_W = 1024;
  localparam int unsigned MAX_H = 1024;
  localparam int unsigned HIST = 2 * (MAX_R * MAX_W + MAX_R) + 1;
  localparam int unsigned SETTLE = 40;
  localparam int unsigned N_ITEMS = 1100;
  localparam longint unsigned LIMIT = 200000;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  wmf_pkg::in_item_t in_data;
  logic out_valid;
  logic out_stall;
  wmf_pkg::out_item_t out_data;
  logic cfg_we;
  logic [wmf_pkg::CFG_AW-1:0] cfg_idx;
  logic [wmf_pkg::CFG_DW-1:0] cfg_data;

  windowed_median_filter_top u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  // Filter state mirrored in the predictor
  logic [1:0] rad_reg;
  logic [10:0] wid_reg;
  logic [10:0] hgt_reg;
  logic [15:0] pix_hist [HIST];
  int unsigned in_r, in_c, out_r, out_c;

  wmf_pkg::out_item_t medians_due[$];
  int unsigned n_fail;
  int unsigned n_sent;
  longint unsigned cycle_cnt;
  bit stall_en;

  int unsigned cur_w, cur_h;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Run guard
  initial begin
    cycle_cnt = 0;
    forever begin
      @(posedge clk);
      cycle_cnt++;
      if (cycle_cnt > LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  function automatic int unsigned eff_rad();
    if (rad_reg < 1) return 1;
    if (rad_reg > MAX_R) return MAX_R;
    return rad_reg;
  endfunction

  function automatic int unsigned clip_dim(int unsigned v, int unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  // Median of the window around (r, c), clipped to the image
  function automatic logic [15:0] window_median(int unsigned r, int unsigned c,
                                                int unsigned w, int unsigned h,
                                                int unsigned rd);
    logic [15:0] vals [$];
    int unsigned r0, r1, c0, c1, n;
    r0 = (r >= rd) ? r - rd : 0;
    r1 = (r + rd < h) ? r + rd : h - 1;
    c0 = (c >= rd) ? c - rd : 0;
    c1 = (c + rd < w) ? c + rd : w - 1;
    for (int unsigned i = r0; i <= r1; i++)
      for (int unsigned j = c0; j <= c1; j++)
        vals = {vals, pix_hist[(i * w + j) % HIST]};
    vals.sort();
    n = vals.size();
    if (n % 2 == 0) return 16'((32'(vals[n/2-1]) + 32'(vals[n/2])) >> 1);
    return vals[n/2];
  endfunction

  function automatic void emit_median(int unsigned w, int unsigned h, int unsigned rd);
    wmf_pkg::out_item_t o;
    bit last;
    last = (out_r == h - 1) && (out_c == w - 1);
    o.median_value = window_median(out_r, out_c, w, h, rd);
    o.frame_end = last;
    medians_due = {medians_due, o};
    if (last) begin
      in_r = 0; in_c = 0; out_r = 0; out_c = 0;
    end else begin
      out_c++;
      if (out_c >= w) begin
        out_c = 0;
        out_r++;
      end
    end
  endfunction

  // Predict the results of one accepted item
  function automatic void predict_item(wmf_pkg::in_item_t it);
    int unsigned w, h, rd, lag, tot, in_lin, out_lin;
    bit done;
    w = clip_dim(wid_reg, MAX_W);
    h = clip_dim(hgt_reg, MAX_H);
    rd = eff_rad();
    lag = rd * w + rd;
    tot = w * h;
    in_lin = in_r * w + in_c;
    out_lin = out_r * w + out_c;
    done = in_r >= h;
    if (it.req_type == wmf_pkg::REQ_PIXEL) begin
      if (done) return;
      pix_hist[in_lin % HIST] = it.pixel;
      in_c++;
      if (in_c >= w) begin
        in_c = 0;
        in_r++;
      end
      in_lin++;
      if (in_lin - out_lin > lag) emit_median(w, h, rd);
    end else begin
      if (!done || out_lin >= tot) return;
      emit_median(w, h, rd);
    end
  endfunction

  // Output checker
  initial begin
    wmf_pkg::out_item_t exp_o;
    n_fail = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        if (medians_due.size() == 0) begin
          $error("unexpected result median_value %0d", out_data.median_value);
          n_fail++;
        end else begin
          exp_o = medians_due.pop_front();
          if (out_data.median_value !== exp_o.median_value) begin
            $error("median_value expected %0d actual %0d",
                   exp_o.median_value, out_data.median_value);
            n_fail++;
          end
          if (out_data.frame_end !== exp_o.frame_end) begin
            $error("frame_end expected %0d actual %0d", exp_o.frame_end, out_data.frame_end);
            n_fail++;
          end
        end
      end
    end
  end

  // Receiver stall pattern
  initial begin
    int unsigned phase;
    out_stall = 1'b0;
    phase = 0;
    forever begin
      @(negedge clk);
      phase++;
      if (!stall_en) out_stall <= 1'b0;
      else if (phase % 300 < 60) out_stall <= 1'b0;
      else out_stall <= ($urandom_range(0, 3) == 0);
    end
  end

  task automatic write_reg(wmf_pkg::cfg_idx_e idx, logic [wmf_pkg::CFG_DW-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == wmf_pkg::CFG_RADIUS) rad_reg = val[1:0];
    else if (idx == wmf_pkg::CFG_WIDTH) wid_reg = val;
    else hgt_reg = val;
    in_r = 0; in_c = 0; out_r = 0; out_c = 0;
  endtask

  // Send one item; caller is at a falling edge
  int unsigned burst_left;
  task automatic send_item(wmf_pkg::in_item_t it);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 4);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    predict_item(it);
    n_sent++;
    burst_left--;
    @(negedge clk);
  endtask

  // Idle the input and wait until every predicted result has come out
  task automatic drain_idle();
    in_valid <= 1'b0;
    while (medians_due.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  function automatic logic [15:0] rand_pix();
    case ($urandom_range(0, 5))
      0: return 16'd0;
      1: return 16'd32768;
      2: return 16'($urandom);
      default: return 16'($urandom_range(0, 32768));
    endcase
  endfunction

  // Whole frame with random content plus flush items to drain it
  task automatic run_frame(int unsigned w, int unsigned h, int unsigned rd);
    wmf_pkg::in_item_t it;
    for (int unsigned k = 0; k < w * h; k++) begin
      it.req_type = wmf_pkg::REQ_PIXEL;
      it.pixel = rand_pix();
      send_item(it);
      if ($urandom_range(0, 30) == 0) begin
        it.req_type = wmf_pkg::REQ_FLUSH;
        it.pixel = 16'($urandom);
        send_item(it);
      end
    end
    for (int unsigned k = 0; k < rd * w + rd + $urandom_range(0, 2); k++) begin
      it.req_type = wmf_pkg::REQ_FLUSH;
      it.pixel = 16'($urandom);
      send_item(it);
    end
  endtask

  task automatic set_geometry(logic [1:0] rd, logic [10:0] w, logic [10:0] h);
    write_reg(wmf_pkg::CFG_RADIUS, {9'd0, rd});
    write_reg(wmf_pkg::CFG_WIDTH, w);
    write_reg(wmf_pkg::CFG_HEIGHT, h);
    cur_w = clip_dim(w, MAX_W);
    cur_h = clip_dim(h, MAX_H);
  endtask

  // Directed rows: kind and pixel; results come from the predictor
  typedef struct {
    wmf_pkg::req_e kind;
    logic [15:0] pix;
  } stim_row_t;

  stim_row_t dir_rows [17];

  initial begin
    wmf_pkg::in_item_t it;
    logic [1:0] rd;
    logic [10:0] w, h;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_idx = wmf_pkg::CFG_RADIUS;
    cfg_data = '0;
    stall_en = 1'b0;
    burst_left = 0;
    n_sent = 0;
    rad_reg = 2'd1;
    wid_reg = 11'd1024;
    hgt_reg = 11'd1024;
    in_r = 0; in_c = 0; out_r = 0; out_c = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: 3x3 frame, radius 1, extremes, early flush, oversized samples
    set_geometry(2'd1, 11'd3, 11'd3);
    dir_rows = '{
      '{wmf_pkg::REQ_FLUSH, 16'd0},     '{wmf_pkg::REQ_PIXEL, 16'd0},
      '{wmf_pkg::REQ_PIXEL, 16'd32768}, '{wmf_pkg::REQ_PIXEL, 16'hFFFF},
      '{wmf_pkg::REQ_PIXEL, 16'd1},     '{wmf_pkg::REQ_PIXEL, 16'd32767},
      '{wmf_pkg::REQ_PIXEL, 16'h5555},  '{wmf_pkg::REQ_PIXEL, 16'hAAAA},
      '{wmf_pkg::REQ_PIXEL, 16'd0},     '{wmf_pkg::REQ_PIXEL, 16'd32768},
      '{wmf_pkg::REQ_PIXEL, 16'd7},     '{wmf_pkg::REQ_FLUSH, 16'hFFFF},
      '{wmf_pkg::REQ_FLUSH, 16'd0},     '{wmf_pkg::REQ_FLUSH, 16'd0},
      '{wmf_pkg::REQ_FLUSH, 16'd0},     '{wmf_pkg::REQ_FLUSH, 16'd0},
      '{wmf_pkg::REQ_PIXEL, 16'd9}
    };
    foreach (dir_rows[i]) begin
      it.req_type = dir_rows[i].kind;
      it.pixel = dir_rows[i].pix;
      send_item(it);
    end
    drain_idle();

    // Out-of-range registers: radius 0 and 3, width and height 0, height above max
    set_geometry(2'd0, 11'd0, 11'd0);
    run_frame(1, 1, 1);
    drain_idle();
    set_geometry(2'd3, 11'd5, 11'd1);
    run_frame(cur_w, cur_h, 2);
    drain_idle();
    set_geometry(2'd2, 11'd1, 11'd2047);
    run_frame(cur_w, 6, 2);
    drain_idle();
    set_geometry(2'd2, 11'd1, 11'd6);
    run_frame(1, 6, 2);
    drain_idle();

    // Random frames, mostly small
    stall_en = 1'b1;
    while (n_sent < N_ITEMS) begin
      rd = 2'($urandom_range(0, 3));
      w = 11'($urandom_range(1, 12));
      h = 11'($urandom_range(1, 10));
      set_geometry(rd, w, h);
      run_frame(cur_w, cur_h, eff_rad());
      drain_idle();
    end

    drain_idle();
    if (n_fail == 0 && medians_due.size() == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
